// ----- sv/usac_pkg.sv -----
// shared types and constants for the unique source address counter
package usac_pkg;

  // default capacity of the address table
  localparam int TABLE_DEPTH_DEF = 128;

  // field widths
  localparam int ADDR_W  = 48;
  localparam int LEN_W   = 16;
  localparam int CHAN_W  = 4;
  localparam int TICK_W  = 16;
  localparam int PKT_W   = 32;
  localparam int TOTAL_W = 8;

  // stream word widths
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_LEN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_CH = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_LAST_CH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DWELL    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPORT   = 3'd4;

  // register values after reset
  localparam logic [LEN_W-1:0]  RST_MIN_LEN  = 16'd36;
  localparam logic [CHAN_W-1:0] RST_FIRST_CH = 4'd1;
  localparam logic [CHAN_W-1:0] RST_LAST_CH  = 4'd13;
  localparam logic [TICK_W-1:0] RST_DWELL    = 16'd250;
  localparam logic [TICK_W-1:0] RST_REPORT   = 16'd1000;

  // lookup request to the address table
  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] addr;
  } lookup_req_t;

  // lookup response from the address table
  typedef struct packed {
    logic done;
    logic is_new;
  } lookup_rsp_t;

  // channel hop and report settings
  typedef struct packed {
    logic [CHAN_W-1:0] first_ch;
    logic [CHAN_W-1:0] last_ch;
    logic [TICK_W-1:0] dwell;
    logic [TICK_W-1:0] report;
  } hop_cfg_t;

  // events and channel for the current tick
  typedef struct packed {
    logic              hop;
    logic              report;
    logic [CHAN_W-1:0] channel_nxt;
    logic [CHAN_W-1:0] channel;
  } hop_stat_t;

endpackage

// ----- sv/unique_source_address_counter.sv -----
// top level: stream ports, configuration registers, packet counter and control
// a tick or a frame that needs no lookup passes from the result registers (S_HOLD) to the output
// register once it is free; a looked-up frame first searches the table, one entry a cycle
// a new word is taken once the result has moved to the output register, so the block takes no
// new item while the previous one is still in the lookup or the result stage
// synchronous active-low reset clears counters, timers and control, sets channel and registers
// to their defaults; table contents stay as they are while the stored count returns to zero
module unique_source_address_counter #(
  parameter int TABLE_DEPTH = usac_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [usac_pkg::IN_DATA_W-1:0]    in_tdata,  // frame_length, source_address
  input  logic                              in_tuser,  // action
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // new_device, table_full, device_total, packet_total, active_channel, channel_hopped
  output logic [usac_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser, // report_valid
  // configuration writes
  input  logic                              cfg_we,
  input  logic [usac_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [usac_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_HOLD   = 3'b100
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;

  logic [usac_pkg::LEN_W-1:0]  min_len_r;
  usac_pkg::hop_cfg_t          hop_cfg_r;
  logic [usac_pkg::PKT_W-1:0]  frame_cnt_r, frame_cnt_nxt;
  logic [usac_pkg::PKT_W-1:0]  pkt_bump;

  logic                        res_new_r, res_new_nxt;
  logic [usac_pkg::PKT_W-1:0]  res_pkt_r, res_pkt_nxt;
  logic [usac_pkg::CHAN_W-1:0] res_ch_r, res_ch_nxt;
  logic                        res_hop_r, res_hop_nxt;
  logic                        res_rep_r, res_rep_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [usac_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                          out_user_r, out_user_nxt;

  logic                        in_accept;
  logic                        is_tick;
  logic [usac_pkg::LEN_W-1:0]  in_len;
  logic [usac_pkg::ADDR_W-1:0] in_addr;
  logic                        long_frame;

  usac_pkg::lookup_req_t lk_req;
  usac_pkg::lookup_rsp_t lk_rsp;
  usac_pkg::hop_stat_t   hop_stat;
  logic [CNT_W-1:0]      tbl_count;
  logic                  tbl_full;

  // input word fields
  assign in_len     = in_tdata[usac_pkg::LEN_W-1:0];
  assign in_addr    = in_tdata[usac_pkg::LEN_W +: usac_pkg::ADDR_W];
  assign is_tick    = in_tuser;
  assign in_tready  = state_r == S_IDLE;
  assign in_accept  = in_tvalid && in_tready;
  assign long_frame = in_len >= min_len_r;
  assign pkt_bump   = (frame_cnt_r != '1) ? frame_cnt_r + usac_pkg::PKT_W'(1) : frame_cnt_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r          <= usac_pkg::RST_MIN_LEN;
      hop_cfg_r.first_ch <= usac_pkg::RST_FIRST_CH;
      hop_cfg_r.last_ch  <= usac_pkg::RST_LAST_CH;
      hop_cfg_r.dwell    <= usac_pkg::RST_DWELL;
      hop_cfg_r.report   <= usac_pkg::RST_REPORT;
    end else if (cfg_we) begin
      case (cfg_addr)
        usac_pkg::CFG_MIN_LEN:  min_len_r          <= cfg_wdata;
        usac_pkg::CFG_FIRST_CH: hop_cfg_r.first_ch <= cfg_wdata[usac_pkg::CHAN_W-1:0];
        usac_pkg::CFG_LAST_CH:  hop_cfg_r.last_ch  <= cfg_wdata[usac_pkg::CHAN_W-1:0];
        usac_pkg::CFG_DWELL:    hop_cfg_r.dwell    <= cfg_wdata;
        usac_pkg::CFG_REPORT:   hop_cfg_r.report   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // address table
  assign lk_req.start = in_accept && !is_tick && long_frame && !tbl_full;
  assign lk_req.addr  = in_addr;

  usac_addr_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lk_req),
    .rsp   (lk_rsp),
    .count (tbl_count),
    .full  (tbl_full)
  );

  // channel hop and report timers
  usac_hop_timer u_timer (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (in_accept && is_tick),
    .cfg   (hop_cfg_r),
    .stat  (hop_stat)
  );

  // item control
  always_comb begin
    state_nxt     = state_r;
    frame_cnt_nxt = frame_cnt_r;
    res_new_nxt   = res_new_r;
    res_pkt_nxt   = res_pkt_r;
    res_ch_nxt    = res_ch_r;
    res_hop_nxt   = res_hop_r;
    res_rep_nxt   = res_rep_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          res_new_nxt = 1'b0;
          if (is_tick) begin
            res_pkt_nxt = frame_cnt_r;
            res_ch_nxt  = hop_stat.channel_nxt;
            res_hop_nxt = hop_stat.hop;
            res_rep_nxt = hop_stat.report;
            if (hop_stat.report) begin
              frame_cnt_nxt = '0;
            end
            state_nxt = S_HOLD;
          end else begin
            res_pkt_nxt   = long_frame ? pkt_bump : frame_cnt_r;
            frame_cnt_nxt = res_pkt_nxt;
            res_ch_nxt    = hop_stat.channel;
            res_hop_nxt   = 1'b0;
            res_rep_nxt   = 1'b0;
            state_nxt     = lk_req.start ? S_LOOKUP : S_HOLD;
          end
        end
      end
      S_LOOKUP: begin
        if (lk_rsp.done) begin
          res_new_nxt = lk_rsp.is_new;
          state_nxt   = S_HOLD;
        end
      end
      S_HOLD: begin
        // move the result into the output register once it is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, res_hop_r, res_ch_r, res_pkt_r,
                           usac_pkg::TOTAL_W'(tbl_count), tbl_full, res_new_r};
          out_user_nxt  = res_rep_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      frame_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    res_new_r  <= res_new_nxt;
    res_pkt_r  <= res_pkt_nxt;
    res_ch_r   <= res_ch_nxt;
    res_hop_r  <= res_hop_nxt;
    res_rep_r  <= res_rep_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("control state not one-hot");

  a_lookup_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOKUP && !lk_rsp.done) |=> state_r == S_LOOKUP)
    else $error("lookup left before the table answered");

  a_tick_direct: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && is_tick) |=> state_r == S_HOLD)
    else $error("tick did not go straight to the result stage");

endmodule

// ----- sv/usac_addr_table.sv -----
// address table memory with a linear search and learn sequencer
module usac_addr_table #(
  parameter int TABLE_DEPTH = usac_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  usac_pkg::lookup_req_t req,
  output usac_pkg::lookup_rsp_t rsp,
  output logic [CNT_W-1:0]      count,
  output logic                  full
);

  // table storage
  logic [usac_pkg::ADDR_W-1:0] mem [TABLE_DEPTH];
  logic [usac_pkg::ADDR_W-1:0] rdata_r;

  logic                        re;
  logic [IDX_W-1:0]            raddr;
  logic                        we;
  logic [IDX_W-1:0]            waddr;
  logic [usac_pkg::ADDR_W-1:0] wdata;

  logic                        busy_r, busy_nxt;
  logic [IDX_W-1:0]            ptr_r, ptr_nxt;
  logic [usac_pkg::ADDR_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        done_r, done_nxt;
  logic                        new_r, new_nxt;
  logic                        last_entry;

  // search step: compare the word read last cycle, then read on or learn
  always_comb begin
    re         = 1'b0;
    raddr      = '0;
    we         = 1'b0;
    waddr      = count_r[IDX_W-1:0];
    wdata      = key_r;
    busy_nxt   = busy_r;
    ptr_nxt    = ptr_r;
    key_nxt    = key_r;
    count_nxt  = count_r;
    done_nxt   = 1'b0;
    new_nxt    = new_r;
    last_entry = (CNT_W'(ptr_r) + CNT_W'(1)) == count_r;
    if (busy_r) begin
      if (rdata_r == key_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        new_nxt  = 1'b0;
      end else if (last_entry) begin
        we        = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        busy_nxt  = 1'b0;
        done_nxt  = 1'b1;
        new_nxt   = 1'b1;
      end else begin
        re      = 1'b1;
        raddr   = ptr_r + IDX_W'(1);
        ptr_nxt = ptr_r + IDX_W'(1);
      end
    end else if (req.start) begin
      key_nxt = req.addr;
      if (count_r == '0) begin
        // empty table: store at once
        we        = 1'b1;
        wdata     = req.addr;
        count_nxt = count_r + CNT_W'(1);
        done_nxt  = 1'b1;
        new_nxt   = 1'b1;
      end else begin
        re       = 1'b1;
        raddr    = '0;
        ptr_nxt  = '0;
        busy_nxt = 1'b1;
      end
    end
  end

  // memory with registered read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
  end

  // search payload
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
    new_r <= new_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.is_new = new_r;
  assign count      = count_r;
  assign full       = count_r == CNT_W'(TABLE_DEPTH);

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("stored count beyond table depth");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (!busy_r && !full))
    else $error("lookup started while busy or full");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("lookup done held for more than one cycle");

endmodule

// ----- sv/usac_hop_timer.sv -----
// dwell and report timers with the channel hop register
module usac_hop_timer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               tick,
  input  usac_pkg::hop_cfg_t cfg,
  output usac_pkg::hop_stat_t stat
);

  logic [usac_pkg::TICK_W-1:0] dwell_r, dwell_nxt;
  logic [usac_pkg::TICK_W-1:0] report_r, report_nxt;
  logic [usac_pkg::CHAN_W-1:0] channel_r, channel_nxt;
  logic [usac_pkg::TICK_W-1:0] dwell_inc;
  logic [usac_pkg::TICK_W-1:0] report_inc;
  logic [usac_pkg::CHAN_W:0]   ch_inc;
  logic                        hop;
  logic                        rep;

  // saturating timer steps and hop target
  always_comb begin
    dwell_inc  = (dwell_r != '1) ? dwell_r + usac_pkg::TICK_W'(1) : dwell_r;
    report_inc = (report_r != '1) ? report_r + usac_pkg::TICK_W'(1) : report_r;
    hop        = dwell_inc >= cfg.dwell;
    rep        = report_inc >= cfg.report;
    ch_inc     = {1'b0, channel_r} + (usac_pkg::CHAN_W + 1)'(1);
    if (hop) begin
      channel_nxt = (ch_inc > {1'b0, cfg.last_ch}) ? cfg.first_ch
                                                   : ch_inc[usac_pkg::CHAN_W-1:0];
      dwell_nxt   = '0;
    end else begin
      channel_nxt = channel_r;
      dwell_nxt   = dwell_inc;
    end
    report_nxt = rep ? '0 : report_inc;
  end

  // timers advance on ticks only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dwell_r   <= '0;
      report_r  <= '0;
      channel_r <= usac_pkg::RST_FIRST_CH;
    end else if (tick) begin
      dwell_r   <= dwell_nxt;
      report_r  <= report_nxt;
      channel_r <= channel_nxt;
    end
  end

  assign stat.hop         = hop;
  assign stat.report      = rep;
  assign stat.channel_nxt = channel_nxt;
  assign stat.channel     = channel_r;

endmodule
